// ===== rtl/core/pru_pkg.sv =====
// ----------------------------------------------------------------------------
// pru_pkg
// Shared widths and constants for the particle rapidity unit.
// ----------------------------------------------------------------------------
package pru_pkg;

	localparam int MOM_W      = 17;
	localparam int MASS_W     = 13;
	localparam int Y_W        = 16;
	localparam int SQ_W       = 33;
	localparam int SUM_W      = 35;
	localparam int ROOT_W     = 56;
	localparam int ROOT_STEPS = 28;
	localparam int EF_W       = 28;
	localparam int LN_W       = 29;
	localparam int EXP_W      = 5;
	localparam int MANT_W     = 31;
	localparam int FRAC_W     = 16;
	localparam int LOG_W      = EXP_W + FRAC_W;
	localparam int COEF_W     = 31;
	localparam int PROD_W     = LOG_W + COEF_W;

	localparam logic [MASS_W-1:0] MASS_RESET   = 13'd961;
	localparam logic [COEF_W-1:0] HALF_LN2_Q32 = 31'd1488522236;
	localparam logic [Y_W-1:0]    Y_MAX        = 16'h7fff;
	localparam logic [Y_W-1:0]    Y_MIN        = 16'h8000;

	localparam logic [2:0] ADDR_MASS = 3'd0;

endpackage

// ===== rtl/core/particle_rapidity_unit_core.sv =====
// ----------------------------------------------------------------------------
// particle_rapidity_unit_core
// Rapidity of one track from its momentum and a programmable particle mass.
// ----------------------------------------------------------------------------
// Throughput is one request per cycle while out_stall does not hold the output.
// Depth is set by the 28-stage restoring square root and the 16 squaring
// stages of the two log2 units; every stage holds together on a stall.
// Reset clears all valid bits and loads MASS_RESET into the mass register.
module particle_rapidity_unit_core import pru_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [MOM_W-1:0]  mom_x,
	input  logic signed [MOM_W-1:0]  mom_y,
	input  logic signed [MOM_W-1:0]  mom_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [Y_W-1:0]    rapidity,
	output logic                     rapidity_valid
);

	logic [MASS_W-1:0] mass_q;
	logic              en;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= MASS_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_MASS) begin
			mass_q <= pwdata[MASS_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_MASS) prdata = {{(32-MASS_W){1'b0}}, mass_q};
	end

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// squares
	logic signed [2*MOM_W-1:0] px_sq, py_sq, pz_sq;
	logic [SQ_W-1:0]           px2_s1, py2_s1, pz2_s1;
	logic [2*MASS_W-1:0]       m2_s1;
	logic signed [MOM_W-1:0]   pz_s1;
	logic                      vld_s1;

	assign px_sq = mom_x * mom_x;
	assign py_sq = mom_y * mom_y;
	assign pz_sq = mom_z * mom_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px2_s1 <= px_sq[SQ_W-1:0];
			py2_s1 <= py_sq[SQ_W-1:0];
			pz2_s1 <= pz_sq[SQ_W-1:0];
			m2_s1  <= mass_q * mass_q;
			pz_s1  <= mom_z;
		end
	end

	// sum of squares
	logic [SUM_W-1:0]        sum_s2;
	logic signed [MOM_W-1:0] pz_s2;
	logic                    vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= SUM_W'(px2_s1) + SUM_W'(py2_s1) + SUM_W'(pz2_s1) + SUM_W'(m2_s1);
			pz_s2  <= pz_s1;
		end
	end

	// restoring square root, one result bit per stage
	logic [ROOT_W-1:0]       rt_rem_sn [0:ROOT_STEPS];
	logic [ROOT_W-1:0]       rt_res_sn [0:ROOT_STEPS];
	logic signed [MOM_W-1:0] rt_pz_sn  [0:ROOT_STEPS];
	logic                    rt_vld_sn [0:ROOT_STEPS];

	assign rt_rem_sn[0] = {{(ROOT_W-SUM_W-20){1'b0}}, sum_s2, 20'b0};
	assign rt_res_sn[0] = '0;
	assign rt_pz_sn[0]  = pz_s2;
	assign rt_vld_sn[0] = vld_s2;

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2*(ROOT_STEPS-1-k));
		logic [ROOT_W-1:0] trial, rem_nx, res_nx;

		always_comb begin
			trial = rt_res_sn[k] + BIT;
			if (rt_rem_sn[k] >= trial) begin
				rem_nx = rt_rem_sn[k] - trial;
				res_nx = (rt_res_sn[k] >> 1) + BIT;
			end else begin
				rem_nx = rt_rem_sn[k];
				res_nx = rt_res_sn[k] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_vld_sn[k+1] <= 1'b0;
			else if (en) rt_vld_sn[k+1] <= rt_vld_sn[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_sn[k+1] <= rem_nx;
				rt_res_sn[k+1] <= res_nx;
				rt_pz_sn[k+1]  <= rt_pz_sn[k];
			end
		end
	end

	// E + pz and E - pz
	logic signed [LN_W-1:0] ef_ext, pz_ext, num, den;
	logic [LN_W-1:0]        num_s3, den_s3;
	logic                   num_bad_s3, den_bad_s3, vld_s3;

	assign ef_ext = $signed({1'b0, rt_res_sn[ROOT_STEPS][EF_W-1:0]});
	assign pz_ext = $signed({{(LN_W-MOM_W-10){rt_pz_sn[ROOT_STEPS][MOM_W-1]}},
		rt_pz_sn[ROOT_STEPS], 10'b0});
	assign num = ef_ext + pz_ext;
	assign den = ef_ext - pz_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= rt_vld_sn[ROOT_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3     <= num;
			den_s3     <= den;
			num_bad_s3 <= num[LN_W-1] || num == '0;
			den_bad_s3 <= den[LN_W-1] || den == '0;
		end
	end

	// normalize to Q30 mantissa
	logic [EXP_W-1:0]  n_num, n_den;
	logic [MANT_W-1:0] m_num, m_den;

	always_comb begin
		n_num = '0;
		n_den = '0;
		for (int i = 0; i < EF_W; i++) begin
			if (num_s3[i]) n_num = EXP_W'(i);
			if (den_s3[i]) n_den = EXP_W'(i);
		end
		m_num = MANT_W'(num_s3[EF_W-1:0]) << (EXP_W'(MANT_W-1) - n_num);
		m_den = MANT_W'(den_s3[EF_W-1:0]) << (EXP_W'(MANT_W-1) - n_den);
	end

	logic [MANT_W-1:0] lg_mn_sn [0:FRAC_W];
	logic [MANT_W-1:0] lg_md_sn [0:FRAC_W];
	logic [FRAC_W-1:0] lg_fn_sn [0:FRAC_W];
	logic [FRAC_W-1:0] lg_fd_sn [0:FRAC_W];
	logic [EXP_W-1:0]  lg_nn_sn [0:FRAC_W];
	logic [EXP_W-1:0]  lg_nd_sn [0:FRAC_W];
	logic              lg_bn_sn [0:FRAC_W];
	logic              lg_bd_sn [0:FRAC_W];
	logic              lg_vld_sn[0:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lg_vld_sn[0] <= 1'b0;
		else if (en) lg_vld_sn[0] <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lg_mn_sn[0] <= m_num;
			lg_md_sn[0] <= m_den;
			lg_fn_sn[0] <= '0;
			lg_fd_sn[0] <= '0;
			lg_nn_sn[0] <= n_num;
			lg_nd_sn[0] <= n_den;
			lg_bn_sn[0] <= num_bad_s3;
			lg_bd_sn[0] <= den_bad_s3;
		end
	end

	// log2 fraction, one bit per squaring stage
	for (genvar j = 0; j < FRAC_W; j++) begin : g_log
		logic [2*MANT_W-1:0] pn, pd;
		logic [MANT_W:0]     tn, td;

		assign pn = lg_mn_sn[j] * lg_mn_sn[j];
		assign pd = lg_md_sn[j] * lg_md_sn[j];
		assign tn = pn[2*MANT_W-1:MANT_W-1];
		assign td = pd[2*MANT_W-1:MANT_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) lg_vld_sn[j+1] <= 1'b0;
			else if (en) lg_vld_sn[j+1] <= lg_vld_sn[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lg_mn_sn[j+1] <= tn[MANT_W] ? tn[MANT_W:1] : tn[MANT_W-1:0];
				lg_md_sn[j+1] <= td[MANT_W] ? td[MANT_W:1] : td[MANT_W-1:0];
				lg_fn_sn[j+1] <= {lg_fn_sn[j][FRAC_W-2:0], tn[MANT_W]};
				lg_fd_sn[j+1] <= {lg_fd_sn[j][FRAC_W-2:0], td[MANT_W]};
				lg_nn_sn[j+1] <= lg_nn_sn[j];
				lg_nd_sn[j+1] <= lg_nd_sn[j];
				lg_bn_sn[j+1] <= lg_bn_sn[j];
				lg_bd_sn[j+1] <= lg_bd_sn[j];
			end
		end
	end

	// log difference, split into sign and magnitude
	logic signed [LOG_W:0] d;
	logic [LOG_W-1:0]      mag_s5;
	logic                  neg_s5, nbad_s5, dbad_s5, vld_s5;

	assign d = $signed({1'b0, lg_nn_sn[FRAC_W], lg_fn_sn[FRAC_W]}) -
		$signed({1'b0, lg_nd_sn[FRAC_W], lg_fd_sn[FRAC_W]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= lg_vld_sn[FRAC_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s5  <= d[LOG_W];
			mag_s5  <= d[LOG_W] ? LOG_W'(-d) : LOG_W'(d);
			nbad_s5 <= lg_bn_sn[FRAC_W];
			dbad_s5 <= lg_bd_sn[FRAC_W];
		end
	end

	// scale by ln(2)/2
	logic [PROD_W-1:0] prod_s6;
	logic              neg_s6, nbad_s6, dbad_s6, vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s6 <= PROD_W'(mag_s5) * PROD_W'(HALF_LN2_Q32);
			neg_s6  <= neg_s5;
			nbad_s6 <= nbad_s5;
			dbad_s6 <= dbad_s5;
		end
	end

	// round, saturate, apply special cases
	logic [PROD_W:0]   rnd;
	logic [PROD_W-36:0] q;
	logic [Y_W-1:0]    y;

	assign rnd = {1'b0, prod_s6} + ((PROD_W+1)'(1) << 35);
	assign q   = rnd[PROD_W:36];

	always_comb begin
		if (neg_s6) begin
			if (q > (PROD_W-35)'(32768)) y = Y_MIN;
			else                         y = Y_W'(-q);
		end else begin
			if (q > (PROD_W-35)'(32767)) y = Y_MAX;
			else                         y = Y_W'(q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dbad_s6) begin
				rapidity       <= '0;
				rapidity_valid <= 1'b0;
			end else if (nbad_s6) begin
				rapidity       <= Y_MIN;
				rapidity_valid <= 1'b1;
			end else begin
				rapidity       <= y;
				rapidity_valid <= 1'b1;
			end
		end
	end

endmodule

// ===== sim/particle_rapidity_unit_core_tb.sv =====
// ----------------------------------------------------------------------------
// particle_rapidity_unit_core_tb
// Drives momentum requests through the rapidity unit under several idle and
// stall patterns and mass settings, and checks every result against an
// integer model of the energy, log2 and rapidity scaling.
// ----------------------------------------------------------------------------
module particle_rapidity_unit_core_tb import pru_pkg::*; ();

	typedef struct packed {
		logic signed [Y_W-1:0] rapidity;
		logic                  rapidity_valid;
	} rap_result_t;

	class rapidity_board;
		rap_result_t pending[$];
		logic [MASS_W-1:0] mass;
		int errors;
		int n_checked;
		int n_undef;

		function new();
			mass = MASS_RESET;
			errors = 0;
			n_checked = 0;
			n_undef = 0;
		endfunction

		function automatic longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function automatic longint log2_fix(longint unsigned x);
			int n;
			longint unsigned m;
			longint f;
			n = 0;
			f = 0;
			while (n < 63 && (x >> (n + 1)) != 0) n++;
			m = (n <= 30) ? (x << (30 - n)) : (x >> (n - 30));
			for (int i = 0; i < FRAC_W; i++) begin
				m = (m * m) >> 30;
				f = f << 1;
				if (m >= (64'd1 << 31)) begin
					m = m >> 1;
					f = f | 1;
				end
			end
			return (longint'(n) << FRAC_W) + f;
		endfunction

		function void note_track(logic signed [MOM_W-1:0] px, logic signed [MOM_W-1:0] py,
				logic signed [MOM_W-1:0] pz);
			longint x, y2, z, m, ef, num, den, d, yv;
			longint unsigned s, mag, q;
			rap_result_t r;
			x = px;
			y2 = py;
			z = pz;
			m = mass;
			s = x * x + y2 * y2 + z * z + m * m;
			ef = int_sqrt(s << 20);
			num = ef + z * 1024;
			den = ef - z * 1024;
			r.rapidity_valid = 1'b1;
			if (den <= 0) begin
				yv = 0;
				r.rapidity_valid = 1'b0;
			end else if (num <= 0) begin
				yv = -32768;
			end else begin
				d = log2_fix(num) - log2_fix(den);
				mag = (d < 0) ? -d : d;
				q = (mag * 64'd1488522236 + (64'd1 << 35)) >> 36;
				yv = (d < 0) ? -longint'(q) : longint'(q);
				if (yv > 32767) yv = 32767;
				if (yv < -32768) yv = -32768;
			end
			r.rapidity = yv[Y_W-1:0];
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [Y_W-1:0] rap, logic vld);
			rap_result_t e;
			n_checked++;
			if (!vld) n_undef++;
			if (pending.size() == 0) begin
				$error("result with no request outstanding: rapidity=%0d", rap);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (rap !== e.rapidity) begin
				$error("rapidity expected %0d got %0d", e.rapidity, rap);
				errors++;
			end
			if (vld !== e.rapidity_valid) begin
				$error("rapidity_valid expected %0b got %0b", e.rapidity_valid, vld);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [MOM_W-1:0] mom_x = '0, mom_y = '0, mom_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [Y_W-1:0] rapidity;
	logic rapidity_valid;

	rapidity_board board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	int quiet_cycles = 0;
	int n_sent = 0;

	localparam int LATENCY = 51;
	localparam int WATCHDOG = 20000;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	particle_rapidity_unit_core u_dut (.*);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_result(rapidity, rapidity_valid);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic write_mass(logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_MASS;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.mass = v[MASS_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_track(logic signed [MOM_W-1:0] px, logic signed [MOM_W-1:0] py,
			logic signed [MOM_W-1:0] pz);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mom_x <= px;
		mom_y <= py;
		mom_z <= pz;
		do @(posedge clk); while (in_stall);
		board.note_track(px, py, pz);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	function automatic logic signed [MOM_W-1:0] rand_mom();
		case ($urandom_range(5))
			0: return MOM_W'($urandom_range(31) - 16);
			1: return MOM_W'($urandom_range(2047) - 1024);
			2: return $urandom_range(1) ? 17'sh0ffff : 17'sh10000;
			default: return MOM_W'($urandom);
		endcase
	endfunction

	task automatic random_phase(int n, int idle, int stall);
		logic signed [MOM_W-1:0] pz;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			pz = rand_mom();
			if ($urandom_range(9) == 0) send_track(0, 0, pz);
			else if ($urandom_range(9) == 0)
				send_track(MOM_W'($urandom_range(3)), MOM_W'($urandom_range(3)), pz);
			else send_track(rand_mom(), rand_mom(), pz);
		end
		drain();
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_track(0, 0, 0);
		send_track(0, 0, 17'sh0ffff);
		send_track(0, 0, 17'sh10000);
		send_track(17'sh0ffff, 17'sh0ffff, 17'sh0ffff);
		send_track(17'sh10000, 17'sh10000, 17'sh10000);
		send_track(17'sh0ffff, 0, 0);
		send_track(0, 17'sh10000, 17'sh0ffff);
		send_track(1, 0, 17'sh0ffff);
		send_track(0, 0, 1);
		send_track(0, 0, -1);
		send_track(-1, -1, 0);
		drain();
		write_mass(32'd0);
		send_track(0, 0, 0);
		send_track(0, 0, 100);
		send_track(0, 0, -100);
		send_track(0, 0, 17'sh10000);
		send_track(3, 0, 17'sh0ffff);
		send_track(0, 1, -5000);
		drain();
		write_mass(32'hffff_ffff);
		send_track(0, 0, 0);
		send_track(0, 0, 17'sh0ffff);
		send_track(0, 0, 17'sh10000);
		send_track(17'sh0ffff, 17'sh10000, 12);
		drain();
		random_phase(120, 0, 0);
		write_mass(32'd139 + ($urandom & 32'hffff_e000));
		random_phase(120, 72, 0);
		write_mass($urandom);
		random_phase(120, 0, 72);
		write_mass(32'd0);
		random_phase(60, 13, 13);
		write_mass(32'h1555);
		random_phase(60, 13, 13);
		write_mass(32'h0aaa);
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			random_phase(100, 0, 0);
		join
		write_mass(32'd961);
		drain();
		$display("Sent %0d tracks, checked %0d results (%0d undefined) over several mass settings",
			n_sent, board.n_checked, board.n_undef);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== particle_rapidity_unit_core.f =====
rtl/core/pru_pkg.sv
rtl/core/particle_rapidity_unit_core.sv
sim/particle_rapidity_unit_core_tb.sv
